/* design/gboc_pkg.sv */
// Shared constants and types for the grid block occupancy classifier.
// No dependencies; imported by every module of the block.
package gboc_pkg;

    localparam int COST_W      = 8;
    localparam int SIDE_W      = 5;
    localparam int QUOT_W      = 6;
    localparam int MAX_SIDE_DEF = 16;
    localparam int SIDE_RESET  = 2;

    localparam logic [COST_W-1:0] COST_FREE    = 8'd0;
    localparam logic [COST_W-1:0] COST_OCC     = 8'd100;
    localparam logic [COST_W-1:0] COST_UNKNOWN = 8'd255;

    localparam logic [COST_W-1:0] OFFSET_MIXED_FREE = 8'd10;
    localparam logic [COST_W-1:0] OFFSET_MIXED_OCC  = 8'd50;

    // Control from the sequencer to the tally counters.
    typedef struct packed {
        logic count;
        logic clear;
    } tally_ctrl_t;

endpackage

/* design/gboc_tally.sv */
// Free, occupied and unknown tallies plus the count of cells seen in a block.
// Depends on gboc_pkg.
module gboc_tally
    import gboc_pkg::*;
#(
    parameter int TW = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tally_ctrl_t       ctrl,
    input  logic [COST_W-1:0] cost,
    output logic [TW-1:0]     free_cnt,
    output logic [TW-1:0]     occ_cnt,
    output logic [TW-1:0]     unk_cnt,
    output logic [TW-1:0]     seen_cnt
);

    logic [TW-1:0] free_reg, occ_reg, unk_reg, seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            free_reg <= '0;
            occ_reg  <= '0;
            unk_reg  <= '0;
            seen_reg <= '0;
        end else if (ctrl.count) begin
            if (cost == COST_FREE) begin
                free_reg <= free_reg + 1'b1;
            end else if (cost == COST_UNKNOWN) begin
                unk_reg <= unk_reg + 1'b1;
            end else begin
                occ_reg <= occ_reg + 1'b1;
            end
            seen_reg <= seen_reg + 1'b1;
        end
    end

    assign free_cnt = free_reg;
    assign occ_cnt  = occ_reg;
    assign unk_cnt  = unk_reg;
    assign seen_cnt = seen_reg;

endmodule

/* design/gboc_divider.sv */
// Restoring divider giving floor(40 * x / n) for x <= n, one quotient bit a cycle.
// Depends on gboc_pkg.
module gboc_divider
    import gboc_pkg::*;
#(
    parameter int TW = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TW-1:0]     x,
    input  logic [TW-1:0]     n,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    localparam int RW    = TW + QUOT_W;
    localparam int STEPW = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

    logic [RW-1:0]     rem_reg, div_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [STEPW-1:0]  step_reg;
    logic              busy_reg, done_reg;
    logic [RW-1:0]     x_ext;
    logic              ge;

    assign x_ext = RW'(x);
    assign ge    = (rem_reg >= div_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                // 40x = 32x + 8x; the divisor starts aligned to the top quotient bit.
                rem_reg  <= (x_ext << 5) + (x_ext << 3);
                div_reg  <= RW'(n) << (QUOT_W - 1);
                quot_reg <= '0;
                step_reg <= STEPW'(QUOT_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (ge) begin
                    rem_reg <= rem_reg - div_reg;
                end
                quot_reg <= {quot_reg[QUOT_W-2:0], ge};
                div_reg  <= div_reg >> 1;
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* design/grid_block_occupancy_classifier.sv */
// Grid block occupancy classifier: counts a square block of fine costs and
// reduces it to one coarse cost. A beat that does not close a block leaves the
// input ready. A closing beat gives its result from the decide state, or from
// the shared divider (six iterations, then its done strobe) when the graded
// cost needs it; an outside-map beat gives 255 in the next cycle. The input is
// not ready from a closing or outside-map beat until its result is taken.
// Synchronous active-low reset clears the tallies and sets the side to 2;
// configuration writes also clear the tallies.
module grid_block_occupancy_classifier
    import gboc_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [SIDE_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [COST_W-1:0] s_sub_cell_cost,
    input  logic              s_outside_map,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [COST_W-1:0] m_coarse_cost
);

    localparam int TW     = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int SW     = $clog2(MAX_SIDE + 1);
    localparam int CW     = (SW > SIDE_W) ? SW : SIDE_W;
    localparam int EW     = TW + 4;
    localparam int SIDE_R = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
    localparam int N_R    = SIDE_R * SIDE_R;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    state_t            state_reg;
    logic [TW-1:0]     n_reg;
    logic              m_valid_reg;
    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] offset_reg;

    logic [CW-1:0]     side_c;
    logic [2*CW-1:0]   side_sq;
    tally_ctrl_t       tctrl;
    logic [TW-1:0]     free_cnt, occ_cnt, unk_cnt, seen_cnt;
    logic              accept, last_cell;
    logic              div_start, div_done;
    logic [TW-1:0]     div_x;
    logic [QUOT_W-1:0] div_quot;
    logic [EW-1:0]     ten_free, ten_unk, free_thr, unk_thr;
    logic              free_wins, unk_excess;

    // Block size from the written side, a zero side taken as one and a larger side clamped to MAX_SIDE.
    always_comb begin
        side_c = CW'(cfg_wdata);
        if (side_c == '0) begin
            side_c = CW'(1);
        end else if (side_c > CW'(MAX_SIDE)) begin
            side_c = CW'(MAX_SIDE);
        end
    end
    assign side_sq = (2*CW)'(side_c) * (2*CW)'(side_c);

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign last_cell = ((TW+1)'(seen_cnt) + 1'b1) >= (TW+1)'(n_reg);

    // free > round(0.8n) holds exactly when 10*free > 8n + 5, and likewise
    // unknown > round(0.4n) when 10*unknown > 4n + 5.
    assign ten_free   = (EW'(free_cnt) << 3) + (EW'(free_cnt) << 1);
    assign ten_unk    = (EW'(unk_cnt) << 3) + (EW'(unk_cnt) << 1);
    assign free_thr   = (EW'(n_reg) << 3) + EW'(5);
    assign unk_thr    = (EW'(n_reg) << 2) + EW'(5);
    assign free_wins  = ten_free > free_thr;
    assign unk_excess = ten_unk > unk_thr;

    logic mixed_free, mixed_occ;
    assign mixed_free = (free_cnt != '0) && (unk_cnt != '0) && (occ_cnt == '0);
    assign mixed_occ  = (free_cnt != '0) && (occ_cnt != '0);

    always_comb begin
        tctrl.count = accept && !s_outside_map;
        tctrl.clear = cfg_we || (accept && s_outside_map) || (state_reg == ST_DECIDE);
    end

    assign div_start = (state_reg == ST_DECIDE) && !free_wins && (occ_cnt != n_reg)
                       && (unk_cnt != n_reg) && (mixed_free || (mixed_occ && !unk_excess));
    assign div_x     = mixed_free ? free_cnt : occ_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_reg       <= TW'(N_R);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                n_reg <= side_sq[TW-1:0];
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_outside_map) begin
                            cost_reg    <= COST_UNKNOWN;
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_OUTPUT;
                        end else if (last_cell) begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    if (div_start) begin
                        offset_reg <= mixed_free ? OFFSET_MIXED_FREE : OFFSET_MIXED_OCC;
                        state_reg  <= ST_DIVIDE;
                    end else begin
                        if (free_wins) begin
                            cost_reg <= COST_FREE;
                        end else if (occ_cnt == n_reg) begin
                            cost_reg <= COST_OCC;
                        end else begin
                            cost_reg <= COST_UNKNOWN;
                        end
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_OUTPUT;
                    end
                end
                ST_DIVIDE: begin
                    if (div_done) begin
                        cost_reg    <= COST_W'(div_quot) + offset_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_OUTPUT;
                    end
                end
                ST_OUTPUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    m_valid_reg <= 1'b0;
                    state_reg   <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_coarse_cost = cost_reg;

    gboc_tally #(
        .TW(TW)
    ) u_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tctrl),
        .cost    (s_sub_cell_cost),
        .free_cnt(free_cnt),
        .occ_cnt (occ_cnt),
        .unk_cnt (unk_cnt),
        .seen_cnt(seen_cnt)
    );

    gboc_divider #(
        .TW(TW)
    ) u_divider (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .x      (div_x),
        .n      (n_reg),
        .done   (div_done),
        .quot   (div_quot)
    );

`ifndef SYNTHESIS
    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result beat is pending");

    a_cost_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_coarse_cost == COST_FREE || m_coarse_cost == COST_OCC ||
                     m_coarse_cost == COST_UNKNOWN ||
                     (m_coarse_cost >= 8'd10 && m_coarse_cost <= 8'd90)))
        else $error("coarse cost outside its legal set");

    a_done_only_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide step");

    a_tallies_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |-> (seen_cnt == '0))
        else $error("tallies not cleared when a result beat leaves");
`endif

endmodule
